// ===== rtl/core/fba_pkg.sv =====
// Package for the fit block allocator: widths, codes, mode enum, FSM states
// and the structs passed between the cells, the register file and the top.
// No dependencies.
`default_nettype none

package fba_pkg;

    localparam int NUM_BLOCKS = 32;
    localparam int SIZE_BITS  = 16;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    localparam int IDX_W      = 5;
    localparam int SCAN_W     = 6;
    localparam int MODE_W     = 2;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_BLOCKS   = 1'b1;

    localparam logic [SCAN_W-1:0] BLOCKS_RESET = SCAN_W'(32);

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEVER = 2'd3
    } fit_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic [SIZE_BITS-1:0] req;
        logic                 found;
        logic [BLK_W-1:0]     idx;
        logic [SIZE_BITS-1:0] val;
    } probe_t;

    typedef struct packed {
        logic                 en;
        logic [BLK_W-1:0]     idx;
        logic [SIZE_BITS-1:0] data;
    } cell_wr_t;

    typedef struct packed {
        fit_mode_t        mode;
        logic [CNT_W-1:0] scan;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/fba_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on fba_pkg.
`default_nettype none

interface fba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [fba_pkg::IDX_W-1:0]     load_index;
    logic [fba_pkg::SIZE_BITS-1:0] size;

    modport source (output valid, command, load_index, size, input ready);
    modport sink   (input valid, command, load_index, size, output ready);
endinterface

interface fba_res_if;
    logic                      valid;
    logic                      ready;
    logic                      granted;
    logic [fba_pkg::IDX_W-1:0] granted_block;

    modport source (output valid, granted, granted_block, input ready);
    modport sink   (input valid, granted, granted_block, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fit_block_allocator_unit.sv =====
// A load is written at its accepting edge. An allocation's probe walks the
// chain of NUM_BLOCKS cells one cell per cycle, then write-back and the pend
// registers, then the result registers, which stall while a result is unread;
// requests are accepted only in idle. Reset: control and probe registers clear,
// config resets to first fit over 32 blocks; block sizes are undefined until
// loaded. Depends on fba_pkg, fba_if, fba_cell, fba_cfg.
`default_nettype none

module fit_block_allocator_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    fba_req_if.sink                         request,
    fba_res_if.source                       result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fba_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fba_pkg::DATA_W-1:0] pwdata,
    output logic      [fba_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    fba_pkg::cfg_t     cfg;
    fba_pkg::cell_wr_t wr;
    fba_pkg::probe_t   probe_head;
    fba_pkg::probe_t   probe_w [0:fba_pkg::NUM_BLOCKS];
    fba_pkg::probe_t   exit_probe;

    fba_pkg::state_t   state_reg;
    fba_pkg::state_t   state_next;

    logic                          req_take;
    logic                          scan_exit;
    logic                          out_load;
    logic                          pend_granted_reg;
    logic [fba_pkg::BLK_W-1:0]     pend_block_reg;
    logic                          res_valid_reg;
    logic                          res_granted_reg;
    logic [fba_pkg::IDX_W-1:0]     res_block_reg;

    fba_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req_take = request.valid && request.ready;

    always_comb
    begin
        probe_head       = '0;
        probe_head.valid = req_take && request.command == fba_pkg::CMD_ALLOC;
        probe_head.req   = request.size;
    end

    assign probe_w[0] = probe_head;

    for (genvar k = 0; k < fba_pkg::NUM_BLOCKS; k++)
    begin : g_cell
        fba_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (fba_pkg::BLK_W'(k)),
            .cfg       (cfg),
            .wr        (wr),
            .probe_in  (probe_w[k]),
            .probe_out (probe_w[k+1])
        );
    end

    assign exit_probe = probe_w[fba_pkg::NUM_BLOCKS];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fba_pkg::ST_IDLE:
            begin
                if (req_take && request.command == fba_pkg::CMD_ALLOC)
                begin
                    state_next = fba_pkg::ST_SCAN;
                end
            end
            fba_pkg::ST_SCAN:
            begin
                if (exit_probe.valid)
                begin
                    state_next = fba_pkg::ST_DONE;
                end
            end
            fba_pkg::ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        request.ready = 1'b0;
        scan_exit     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            fba_pkg::ST_IDLE:
            begin
                request.ready = 1'b1;
            end
            fba_pkg::ST_SCAN:
            begin
                scan_exit = exit_probe.valid;
            end
            fba_pkg::ST_DONE:
            begin
                out_load = !res_valid_reg || result.ready;
            end
            default:
            begin
                request.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr = '0;
        if (scan_exit && exit_probe.found)
        begin
            wr.en   = 1'b1;
            wr.idx  = exit_probe.idx;
            wr.data = exit_probe.val - exit_probe.req;
        end
        else if (req_take && request.command == fba_pkg::CMD_LOAD
                 && 32'(request.load_index) < fba_pkg::NUM_BLOCKS)
        begin
            wr.en   = 1'b1;
            wr.idx  = fba_pkg::BLK_W'(request.load_index);
            wr.data = request.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fba_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_exit)
        begin
            pend_granted_reg <= exit_probe.found;
            pend_block_reg   <= exit_probe.found ? exit_probe.idx : '0;
        end
        if (out_load)
        begin
            res_granted_reg <= pend_granted_reg;
            res_block_reg   <= fba_pkg::IDX_W'(pend_block_reg);
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.granted       = res_granted_reg;
    assign result.granted_block = res_block_reg;

`ifndef SYNTHESIS
    a_ready_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        request.ready |-> state_reg == fba_pkg::ST_IDLE)
        else $error("request ready outside idle");

    a_exit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        exit_probe.valid |-> state_reg == fba_pkg::ST_SCAN)
        else $error("probe left chain outside scan");

    a_pick_in_scope: assert property (@(posedge clk) disable iff (!rst_n)
        scan_exit && exit_probe.found
        |-> fba_pkg::CNT_W'(exit_probe.idx) < cfg.scan
            && cfg.mode != fba_pkg::FIT_NEVER
            && exit_probe.val >= exit_probe.req)
        else $error("granted block outside scan range or too small");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.granted |-> result.granted_block == '0)
        else $error("nonzero block on refused request");

    a_out_follows_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result.valid && state_reg == fba_pkg::ST_IDLE)
        else $error("result not presented after scan");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/fba_cell.sv =====
// One allocator cell: holds one block's remaining size and refines the
// passing search probe before handing it to the next cell. Depends on fba_pkg.
`default_nettype none

module fba_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [fba_pkg::BLK_W-1:0] cell_idx,
    input  wire fba_pkg::cfg_t             cfg,
    input  wire fba_pkg::cell_wr_t         wr,
    input  wire fba_pkg::probe_t           probe_in,
    output fba_pkg::probe_t                probe_out
);

    logic [fba_pkg::SIZE_BITS-1:0] value_reg;
    fba_pkg::probe_t               probe_reg;
    fba_pkg::probe_t               probe_next;
    logic                          in_scope;
    logic                          fits;
    logic                          better;
    logic                          take;

    always_comb
    begin
        in_scope = fba_pkg::CNT_W'(cell_idx) < cfg.scan;
        fits     = value_reg >= probe_in.req;
        better   = !probe_in.found
                || (cfg.mode == fba_pkg::FIT_BEST  && value_reg < probe_in.val)
                || (cfg.mode == fba_pkg::FIT_WORST && value_reg > probe_in.val);
        take     = probe_in.valid && in_scope && fits && better
                && cfg.mode != fba_pkg::FIT_NEVER;
        probe_next = probe_in;
        if (take)
        begin
            probe_next.found = 1'b1;
            probe_next.idx   = cell_idx;
            probe_next.val   = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == cell_idx)
        begin
            value_reg <= wr.data;
        end
    end

    assign probe_out = probe_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fba_cfg.sv =====
// APB register file for fit mode and scan count; saturates the scan count.
// Depends on fba_pkg.
`default_nettype none

module fba_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fba_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fba_pkg::DATA_W-1:0] pwdata,
    output logic      [fba_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output fba_pkg::cfg_t                   cfg
);

    fba_pkg::fit_mode_t             fit_mode_reg;
    logic [fba_pkg::SCAN_W-1:0]     blocks_reg;
    logic                           wr_en;
    logic                           sel;

    assign pready = 1'b1;
    assign sel    = paddr[2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= fba_pkg::FIT_FIRST;
            blocks_reg   <= fba_pkg::BLOCKS_RESET;
        end
        else if (wr_en)
        begin
            if (sel == fba_pkg::REG_FIT_MODE)
            begin
                fit_mode_reg <= fba_pkg::fit_mode_t'(pwdata[fba_pkg::MODE_W-1:0]);
            end
            else
            begin
                blocks_reg <= pwdata[fba_pkg::SCAN_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (sel == fba_pkg::REG_FIT_MODE)
        begin
            prdata = fba_pkg::DATA_W'(fit_mode_reg);
        end
        else
        begin
            prdata = fba_pkg::DATA_W'(blocks_reg);
        end
    end

    always_comb
    begin
        cfg.mode = fit_mode_reg;
        if (32'(blocks_reg) > fba_pkg::NUM_BLOCKS)
        begin
            cfg.scan = fba_pkg::CNT_W'(fba_pkg::NUM_BLOCKS);
        end
        else
        begin
            cfg.scan = fba_pkg::CNT_W'(blocks_reg);
        end
    end

endmodule

`default_nettype wire

// ===== verif/fit_block_allocator_unit_test.sv =====
// Self-checking testbench for fit_block_allocator_unit: a directed stimulus table, then random
// load and allocation requests over several fit modes and scan counts, with grants predicted.
// Depends on fba_pkg, fba_if and the allocator RTL.
`timescale 1ns / 1ps

module fit_block_allocator_unit_test;

    import fba_pkg::*;

    localparam int DRAIN_CYCLES = NUM_BLOCKS + 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 16;
    localparam int DIR_N        = 24;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] blk;
    } grant_t;

    typedef struct packed {
        logic                 set_cfg;
        fit_mode_t            mode;
        logic [SCAN_W-1:0]    blocks;
        logic                 cmd;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
        logic                 typed;
        grant_t               want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    fba_req_if req_ch ();
    fba_res_if res_ch ();

    fit_block_allocator_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [SIZE_BITS-1:0] block_left [NUM_BLOCKS];
    fit_mode_t            mode_now;
    logic [SCAN_W-1:0]    scan_count;
    grant_t               grant_queue [$];
    grant_t               head;
    int                   fail_count;
    int                   idle_cycles;
    int                   src_idle_pct;
    int                   sink_idle_pct;

    row_t dir_rows [DIR_N] = '{
        '{1'b0, FIT_FIRST, 6'd32, CMD_ALLOC, 5'd0,  16'd0,     1'b1, '{1'b1, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_ALLOC, 5'd0,  16'd1,     1'b1, '{1'b0, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_LOAD,  5'd31, 16'hFFFF,  1'b0, '{1'b0, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_ALLOC, 5'd0,  16'hFFFF,  1'b1, '{1'b1, 5'd31}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_ALLOC, 5'd0,  16'd1,     1'b1, '{1'b0, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_LOAD,  5'd5,  16'd100,   1'b0, '{1'b0, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_LOAD,  5'd9,  16'd50,    1'b0, '{1'b0, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_LOAD,  5'd20, 16'd70,    1'b0, '{1'b0, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_LOAD,  5'd3,  16'd40,    1'b0, '{1'b0, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd32, CMD_LOAD,  5'd4,  16'd40,    1'b0, '{1'b0, 5'd0}},
        '{1'b1, FIT_BEST,  6'd32, CMD_ALLOC, 5'd0,  16'd40,    1'b0, '{1'b0, 5'd0}},
        '{1'b0, FIT_BEST,  6'd32, CMD_ALLOC, 5'd0,  16'd45,    1'b0, '{1'b0, 5'd0}},
        '{1'b1, FIT_WORST, 6'd32, CMD_ALLOC, 5'd0,  16'd10,    1'b0, '{1'b0, 5'd0}},
        '{1'b0, FIT_WORST, 6'd32, CMD_ALLOC, 5'd0,  16'd10,    1'b0, '{1'b0, 5'd0}},
        '{1'b1, FIT_NEVER, 6'd32, CMD_ALLOC, 5'd0,  16'd0,     1'b1, '{1'b0, 5'd0}},
        '{1'b1, FIT_FIRST, 6'd0,  CMD_ALLOC, 5'd0,  16'd0,     1'b1, '{1'b0, 5'd0}},
        '{1'b1, FIT_FIRST, 6'd63, CMD_ALLOC, 5'd0,  16'd0,     1'b1, '{1'b1, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd63, CMD_LOAD,  5'd0,  16'hFFFF,  1'b0, '{1'b0, 5'd0}},
        '{1'b1, FIT_FIRST, 6'd1,  CMD_ALLOC, 5'd0,  16'hFFFF,  1'b1, '{1'b1, 5'd0}},
        '{1'b0, FIT_FIRST, 6'd1,  CMD_ALLOC, 5'd0,  16'd1,     1'b1, '{1'b0, 5'd0}},
        '{1'b1, FIT_BEST,  6'd33, CMD_ALLOC, 5'd0,  16'd30,    1'b0, '{1'b0, 5'd0}},
        '{1'b1, FIT_WORST, 6'd2,  CMD_ALLOC, 5'd0,  16'd0,     1'b0, '{1'b0, 5'd0}},
        '{1'b0, FIT_WORST, 6'd2,  CMD_LOAD,  5'd31, 16'h5AA5,  1'b0, '{1'b0, 5'd0}},
        '{1'b1, FIT_FIRST, 6'd32, CMD_ALLOC, 5'd0,  16'h5AA5,  1'b0, '{1'b0, 5'd0}}
    };

    function automatic grant_t predict_grant(input logic cmd, input logic [IDX_W-1:0] idx,
                                             input logic [SIZE_BITS-1:0] sz);
        int     lim;
        int     pick;
        logic   hit;
        grant_t g;
        g = '0;
        if (cmd == CMD_LOAD)
        begin
            block_left[idx] = sz;
            return g;
        end
        lim  = (int'(scan_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);
        hit  = 1'b0;
        pick = 0;
        if (mode_now != FIT_NEVER)
        begin
            for (int k = 0; k < lim; k++)
            begin
                if (block_left[k] >= sz)
                begin
                    if (!hit)
                    begin
                        hit  = 1'b1;
                        pick = k;
                        if (mode_now == FIT_FIRST)
                            break;
                    end
                    else if (mode_now == FIT_BEST && block_left[k] < block_left[pick])
                        pick = k;
                    else if (mode_now == FIT_WORST && block_left[k] > block_left[pick])
                        pick = k;
                end
            end
        end
        if (hit)
        begin
            block_left[pick] = block_left[pick] - sz;
            g.granted = 1'b1;
            g.blk     = IDX_W'(pick);
        end
        return g;
    endfunction

    task automatic push_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                input logic [SIZE_BITS-1:0] sz, input logic typed,
                                input grant_t fixed);
        grant_t pred;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.load_index <= idx;
        req_ch.size       <= sz;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        pred = predict_grant(cmd, idx, sz);
        if (cmd == CMD_ALLOC)
            grant_queue.push_back(typed ? fixed : pred);
    endtask

    task automatic write_register(input logic which, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (which == REG_FIT_MODE)
            mode_now = fit_mode_t'(data[MODE_W-1:0]);
        else
            scan_count = data[SCAN_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid, drain all grants, then let the block settle before writing
    task automatic drain_grants();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (grant_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input fit_mode_t m, input logic [SCAN_W-1:0] b);
        drain_grants();
        write_register(REG_FIT_MODE, ($urandom() << MODE_W) | DATA_W'(m));
        write_register(REG_BLOCKS, ($urandom() << SCAN_W) | DATA_W'(b));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (grant_queue.size() == 0)
            begin
                $error("granted: no request pending, got %0d block %0d",
                       res_ch.granted, res_ch.granted_block);
                fail_count++;
            end
            else
            begin
                head = grant_queue.pop_front();
                if (res_ch.granted !== head.granted)
                begin
                    $error("granted: expected %0d, got %0d", head.granted, res_ch.granted);
                    fail_count++;
                end
                if (res_ch.granted_block !== head.blk)
                begin
                    $error("granted_block: expected %0d, got %0d",
                           head.blk, res_ch.granted_block);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int                   n_items;
        int                   r;
        logic                 c;
        logic [IDX_W-1:0]     li;
        logic [SIZE_BITS-1:0] sz;
        fit_mode_t            m;
        logic [SCAN_W-1:0]    b;
        grant_t               none;

        none              = '0;
        fail_count        = 0;
        src_idle_pct      = 0;
        sink_idle_pct     = 0;
        mode_now          = FIT_FIRST;
        scan_count        = BLOCKS_RESET;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_LOAD;
        req_ch.load_index = '0;
        req_ch.size       = '0;
        for (int k = 0; k < NUM_BLOCKS; k++)
            block_left[k] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // load every entry so no scan touches an unwritten block
        for (int k = 0; k < NUM_BLOCKS; k++)
            push_request(CMD_LOAD, IDX_W'(k), '0, 1'b0, none);

        for (int k = 0; k < DIR_N; k++)
        begin
            if (dir_rows[k].set_cfg)
                set_config(dir_rows[k].mode, dir_rows[k].blocks);
            push_request(dir_rows[k].cmd, dir_rows[k].idx, dir_rows[k].size,
                         dir_rows[k].typed, dir_rows[k].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       b = 6'd32;
                1:       b = 6'd63;
                2:       b = 6'd1;
                3:       b = 6'd0;
                4:       b = 6'd33;
                5:       b = 6'd31;
                default: b = SCAN_W'($urandom_range(2, 63));
            endcase
            m = (phase < 4) ? fit_mode_t'(phase) : fit_mode_t'($urandom_range(0, 3));
            set_config(m, b);
            case (phase % 4)
                0:       begin src_idle_pct = 0;  sink_idle_pct = 0;  end
                1:       begin src_idle_pct = 68; sink_idle_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_idle_pct = 68; end
                default: begin src_idle_pct = 7;  sink_idle_pct = 7;  end
            endcase
            n_items = (b == 0) ? 30 : 112;
            for (int n = 0; n < n_items; n++)
            begin
                c  = ($urandom_range(0, 99) < 40) ? CMD_LOAD : CMD_ALLOC;
                li = IDX_W'($urandom());
                r  = $urandom_range(0, 9);
                if (c == CMD_LOAD)
                begin
                    if (r < 7)
                        sz = SIZE_BITS'($urandom_range(0, 255));
                    else if (r < 9)
                        sz = SIZE_BITS'($urandom());
                    else
                        sz = '1;
                end
                else
                begin
                    if (r < 4)
                        sz = SIZE_BITS'($urandom_range(0, 64));
                    else if (r < 6)
                        sz = block_left[$urandom_range(0, NUM_BLOCKS - 1)];
                    else if (r < 8)
                        sz = SIZE_BITS'($urandom_range(0, 300));
                    else if (r < 9)
                        sz = SIZE_BITS'($urandom());
                    else
                        sz = '0;
                end
                push_request(c, li, sz, 1'b0, none);
            end
        end

        drain_grants();
        if (fail_count == 0 && grant_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fba_pkg.sv
rtl/core/fba_if.sv
rtl/core/fba_cell.sv
rtl/core/fba_cfg.sv
rtl/core/fit_block_allocator_unit.sv
verif/fit_block_allocator_unit_test.sv
